@@ sv/omni_ik_pkg.sv @@
// Shared types, constants and trigonometry helpers for the omni wheel kinematics block.
package omni_ik_pkg;

	// Angle constants in whole degrees.
	localparam logic [8:0] DEG_ZERO          = 9'd0;
	localparam logic [8:0] DEG_QUARTER       = 9'd90;
	localparam logic [8:0] DEG_HALF          = 9'd180;
	localparam logic [8:0] DEG_THREE_QUARTER = 9'd270;
	localparam logic [8:0] DEG_FULL          = 9'd360;

	// Reciprocal of 360 scaled by 2^24, rounded up; exact floor for magnitudes up to 32768.
	localparam logic [15:0] RECIP_360 = 16'd46604;

	// Saturation limits of a wheel rate.
	localparam logic signed [23:0] RATE_MAX = 24'sh7FFFFF;
	localparam logic signed [23:0] RATE_MIN = 24'sh800000;

	// Configuration register indexes.
	typedef logic [2:0] cfg_index_t;
	localparam cfg_index_t REG_WHEEL_ONE_ANGLE   = 3'd0;
	localparam cfg_index_t REG_WHEEL_TWO_ANGLE   = 3'd1;
	localparam cfg_index_t REG_WHEEL_THREE_ANGLE = 3'd2;
	localparam cfg_index_t REG_CENTER_DISTANCE   = 3'd3;
	localparam cfg_index_t REG_INV_WHEEL_RADIUS  = 3'd4;

	// Stage advance enables handed from the pipeline control to the datapath.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
		logic s7;
	} pipe_en_t;

	// Sine and cosine of one angle in Q1.15.
	typedef struct packed {
		logic signed [16:0] sin_v;
		logic signed [16:0] cos_v;
	} trig_t;

	// Quarter-wave sine table, round(32768*sin(d)) for d = 0..90, with 1.0 held as 32767.
	localparam logic [15:0] SIN_Q15 [0:90] = '{
		16'd0,     16'd572,   16'd1144,  16'd1715,  16'd2286,  16'd2856,  16'd3425,
		16'd3993,  16'd4560,  16'd5126,  16'd5690,  16'd6253,  16'd6813,  16'd7371,
		16'd7927,  16'd8481,  16'd9032,  16'd9580,  16'd10126, 16'd10668, 16'd11207,
		16'd11743, 16'd12275, 16'd12803, 16'd13328, 16'd13848, 16'd14365, 16'd14876,
		16'd15384, 16'd15886, 16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
		16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622, 16'd21063, 16'd21498,
		16'd21926, 16'd22348, 16'd22763, 16'd23170, 16'd23571, 16'd23965, 16'd24351,
		16'd24730, 16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510, 16'd26842,
		16'd27166, 16'd27482, 16'd27789, 16'd28088, 16'd28378, 16'd28660, 16'd28932,
		16'd29197, 16'd29452, 16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
		16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499, 16'd31651, 16'd31795,
		16'd31928, 16'd32052, 16'd32166, 16'd32270, 16'd32365, 16'd32449, 16'd32524,
		16'd32588, 16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763, 16'd32767
	};

	// Sine of an angle below 360 degrees through quadrant symmetry.
	function automatic logic signed [16:0] sin_deg(input logic [8:0] d);
		logic [8:0]  idx;
		logic        negate;
		logic [16:0] mag;
		if (d <= DEG_QUARTER) begin
			idx    = d;
			negate = 1'b0;
		end else if (d <= DEG_HALF) begin
			idx    = DEG_HALF - d;
			negate = 1'b0;
		end else if (d <= DEG_THREE_QUARTER) begin
			idx    = d - DEG_HALF;
			negate = 1'b1;
		end else begin
			idx    = DEG_FULL - d;
			negate = 1'b1;
		end
		mag = {1'b0, SIN_Q15[idx[6:0]]};
		return negate ? -signed'(mag) : signed'(mag);
	endfunction

	// Cosine as the sine a quarter turn ahead.
	function automatic logic signed [16:0] cos_deg(input logic [8:0] d);
		logic [9:0] t;
		t = {1'b0, d} + {1'b0, DEG_QUARTER};
		if (t >= {1'b0, DEG_FULL}) begin
			t = t - {1'b0, DEG_FULL};
		end
		return sin_deg(t[8:0]);
	endfunction

	// Sine and cosine pair of an angle below 360 degrees.
	function automatic trig_t trig_of(input logic [8:0] d);
		trig_t r;
		r.sin_v = sin_deg(d);
		r.cos_v = cos_deg(d);
		return r;
	endfunction

endpackage

@@ sv/omni_ik_velocity.sv @@
// Heading reduction, body velocity components and turn term (pipeline stages one to three).
module omni_ik_velocity (
	input  logic                     clk,
	input  omni_ik_pkg::pipe_en_t    en,
	input  logic signed [15:0]       body_speed,
	input  logic signed [15:0]       heading_deg,
	input  logic signed [15:0]       turn_rate,
	input  logic [15:0]              center_distance,
	output logic signed [31:0]       vx,
	output logic signed [31:0]       vy,
	output logic signed [32:0]       turn_term
);

	logic [15:0]        head_abs;
	logic [31:0]        quo_prod;
	logic signed [32:0] turn_term_c;

	logic [15:0]        head_abs_s1;
	logic               head_neg_s1;
	logic [6:0]         quo_s1;
	logic signed [15:0] speed_s1;
	logic signed [32:0] turn_term_s1;

	logic [15:0]        quo_times;
	logic [15:0]        rem_full;
	logic [8:0]         rem;
	logic [8:0]         heading_c;

	logic [8:0]         heading_s2;
	logic signed [15:0] speed_s2;
	logic signed [32:0] turn_term_s2;

	omni_ik_pkg::trig_t head_trig;

	logic signed [31:0] vx_s3;
	logic signed [31:0] vy_s3;
	logic signed [32:0] turn_term_s3;

	// Stage one: heading magnitude, quotient by 360 through the reciprocal, turn term.
	always_comb begin
		head_abs    = heading_deg[15] ? 16'(-heading_deg) : 16'(heading_deg);
		quo_prod    = head_abs * omni_ik_pkg::RECIP_360;
		turn_term_c = signed'({1'b0, center_distance}) * turn_rate;
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			head_abs_s1  <= head_abs;
			head_neg_s1  <= heading_deg[15];
			quo_s1       <= quo_prod[30:24];
			speed_s1     <= body_speed;
			turn_term_s1 <= turn_term_c;
		end
	end

	// Stage two: remainder, folded into 0..359 when the heading was negative.
	always_comb begin
		quo_times = {9'd0, quo_s1} * {7'd0, omni_ik_pkg::DEG_FULL};
		rem_full  = head_abs_s1 - quo_times;
		rem       = rem_full[8:0];
		if (head_neg_s1 && (rem != omni_ik_pkg::DEG_ZERO)) begin
			heading_c = omni_ik_pkg::DEG_FULL - rem;
		end else begin
			heading_c = rem;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			heading_s2   <= heading_c;
			speed_s2     <= speed_s1;
			turn_term_s2 <= turn_term_s1;
		end
	end

	// Stage three: velocity components from the heading table lookup.
	assign head_trig = omni_ik_pkg::trig_of(heading_s2);

	always_ff @(posedge clk) begin
		if (en.s3) begin
			vx_s3        <= speed_s2 * head_trig.cos_v;
			vy_s3        <= speed_s2 * head_trig.sin_v;
			turn_term_s3 <= turn_term_s2;
		end
	end

	assign vx        = vx_s3;
	assign vy        = vy_s3;
	assign turn_term = turn_term_s3;

endmodule

@@ sv/omni_ik_wheel.sv @@
// One wheel lane: mount projection, Q8 rounding, radius scaling and saturation (stages four to seven).
module omni_ik_wheel (
	input  logic                     clk,
	input  omni_ik_pkg::pipe_en_t    en,
	input  logic [8:0]               angle,
	input  logic [15:0]              inverse_wheel_radius,
	input  logic signed [31:0]       vx,
	input  logic signed [31:0]       vy,
	input  logic signed [32:0]       turn_term,
	output logic signed [23:0]       rate
);

	logic [8:0]         angle_red;
	omni_ik_pkg::trig_t mount_trig_q;

	logic signed [48:0] prod_cos_s4;
	logic signed [48:0] prod_sin_s4;
	logic signed [32:0] turn_term_s4;

	logic signed [63:0] turn_wide;
	logic signed [63:0] sum;
	logic signed [41:0] q8_s5;

	logic [20:0]        q8_lo;
	logic signed [20:0] q8_hi;
	logic [37:0]        prod_lo_s6;
	logic signed [37:0] prod_hi_s6;

	logic signed [59:0] hi_wide;
	logic signed [59:0] total;
	logic signed [43:0] rounded;
	logic signed [23:0] rate_c;
	logic signed [23:0] rate_s7;

	// Mount angle trig, refreshed from the register every cycle.
	always_comb begin
		if (angle >= omni_ik_pkg::DEG_FULL) begin
			angle_red = angle - omni_ik_pkg::DEG_FULL;
		end else begin
			angle_red = angle;
		end
	end

	always_ff @(posedge clk) begin
		mount_trig_q <= omni_ik_pkg::trig_of(angle_red);
	end

	// Stage four: project the body velocity onto the wheel direction.
	always_ff @(posedge clk) begin
		if (en.s4) begin
			prod_cos_s4  <= vy * mount_trig_q.cos_v;
			prod_sin_s4  <= vx * mount_trig_q.sin_v;
			turn_term_s4 <= turn_term;
		end
	end

	// Stage five: exact Q.30 sum, rounded half up to Q.8.
	always_comb begin
		turn_wide = turn_term_s4;
		sum = (turn_wide <<< 30) + prod_cos_s4 - prod_sin_s4 + 64'sd2097152;
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			q8_s5 <= sum[63:22];
		end
	end

	// Stage six: split the radius product into two partial products, rounding folded in.
	always_comb begin
		q8_lo = q8_s5[20:0];
		q8_hi = q8_s5[41:21];
	end

	always_ff @(posedge clk) begin
		if (en.s6) begin
			prod_lo_s6 <= 38'(q8_lo) * 38'(inverse_wheel_radius) + 38'd32768;
			prod_hi_s6 <= q8_hi * signed'({1'b0, inverse_wheel_radius});
		end
	end

	// Stage seven: recombine, drop the Q16 fraction and saturate.
	always_comb begin
		hi_wide = prod_hi_s6;
		total   = (hi_wide <<< 21) + signed'({22'd0, prod_lo_s6});
		rounded = total[59:16];
		if (rounded > 44'(omni_ik_pkg::RATE_MAX)) begin
			rate_c = omni_ik_pkg::RATE_MAX;
		end else if (rounded < 44'(omni_ik_pkg::RATE_MIN)) begin
			rate_c = omni_ik_pkg::RATE_MIN;
		end else begin
			rate_c = rounded[23:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en.s7) begin
			rate_s7 <= rate_c;
		end
	end

	assign rate = rate_s7;

endmodule

@@ sv/omni_wheel_inverse_kinematics.sv @@
// Top level of the four-wheel omni drive inverse kinematics pipeline.
//
// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid/s_axis_tready   tdata[47:0]: body_speed, heading_deg, turn_rate
// m_axis    out        m_axis_tvalid/m_axis_tready   tdata[95:0]: wheel one to four rates
// cfg       in         cfg_we                        cfg_index selects register, cfg_data value
//
// Seven register stages; an item enters every cycle while the pipeline is not stalled.
// The stages cover the heading reduction, the two multiplier stages per wheel and the
// split radius product; the 24-bit output register is the last stage.
// Reset clears every valid bit and loads the register defaults.
// A stage holds its item while the next one is full and stalled; empty stages still fill,
// so the input takes items while a finished result waits at the output, until every stage is full.
module omni_wheel_inverse_kinematics (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// Fields from bit 0: body_speed[15:0], heading_deg[31:16], turn_rate[47:32].
	input  logic [47:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// Fields from bit 0: wheel_one_rate[23:0], wheel_two_rate[47:24],
	// wheel_three_rate[71:48], wheel_four_rate[95:72].
	output logic [95:0] m_axis_tdata,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic [8:0]  wheel_one_angle_q;
	logic [8:0]  wheel_two_angle_q;
	logic [8:0]  wheel_three_angle_q;
	logic [15:0] center_distance_q;
	logic [15:0] inverse_wheel_radius_q;

	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	logic valid_s4;
	logic valid_s5;
	logic valid_s6;
	logic valid_s7;

	omni_ik_pkg::pipe_en_t en;

	logic signed [31:0] vx;
	logic signed [31:0] vy;
	logic signed [32:0] turn_term;

	logic signed [23:0] wheel_one_rate;
	logic signed [23:0] wheel_two_rate;
	logic signed [23:0] wheel_three_rate;
	logic signed [23:0] wheel_four_rate;

	// Configuration registers; writes to unused indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wheel_one_angle_q      <= 9'd90;
			wheel_two_angle_q      <= 9'd180;
			wheel_three_angle_q    <= 9'd270;
			center_distance_q      <= 16'd100;
			inverse_wheel_radius_q <= 16'd5120;
		end else if (cfg_we) begin
			unique case (cfg_index)
				omni_ik_pkg::REG_WHEEL_ONE_ANGLE:   wheel_one_angle_q      <= cfg_data[8:0];
				omni_ik_pkg::REG_WHEEL_TWO_ANGLE:   wheel_two_angle_q      <= cfg_data[8:0];
				omni_ik_pkg::REG_WHEEL_THREE_ANGLE: wheel_three_angle_q    <= cfg_data[8:0];
				omni_ik_pkg::REG_CENTER_DISTANCE:   center_distance_q      <= cfg_data;
				omni_ik_pkg::REG_INV_WHEEL_RADIUS:  inverse_wheel_radius_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage enables: a stage advances when it is empty or the next stage advances.
	always_comb begin
		en.s7 = !valid_s7 || m_axis_tready;
		en.s6 = !valid_s6 || en.s7;
		en.s5 = !valid_s5 || en.s6;
		en.s4 = !valid_s4 || en.s5;
		en.s3 = !valid_s3 || en.s4;
		en.s2 = !valid_s2 || en.s3;
		en.s1 = !valid_s1 || en.s2;
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			if (en.s1) valid_s1 <= s_axis_tvalid;
			if (en.s2) valid_s2 <= valid_s1;
			if (en.s3) valid_s3 <= valid_s2;
			if (en.s4) valid_s4 <= valid_s3;
			if (en.s5) valid_s5 <= valid_s4;
			if (en.s6) valid_s6 <= valid_s5;
			if (en.s7) valid_s7 <= valid_s6;
		end
	end

	assign s_axis_tready = en.s1;
	assign m_axis_tvalid = valid_s7;

	// Heading and body velocity stages.
	omni_ik_velocity u_velocity (
		.clk             (clk),
		.en              (en),
		.body_speed      (signed'(s_axis_tdata[15:0])),
		.heading_deg     (signed'(s_axis_tdata[31:16])),
		.turn_rate       (signed'(s_axis_tdata[47:32])),
		.center_distance (center_distance_q),
		.vx              (vx),
		.vy              (vy),
		.turn_term       (turn_term)
	);

	// Four wheel lanes; wheel four sits at zero degrees.
	omni_ik_wheel u_wheel_one (
		.clk                  (clk),
		.en                   (en),
		.angle                (wheel_one_angle_q),
		.inverse_wheel_radius (inverse_wheel_radius_q),
		.vx                   (vx),
		.vy                   (vy),
		.turn_term            (turn_term),
		.rate                 (wheel_one_rate)
	);

	omni_ik_wheel u_wheel_two (
		.clk                  (clk),
		.en                   (en),
		.angle                (wheel_two_angle_q),
		.inverse_wheel_radius (inverse_wheel_radius_q),
		.vx                   (vx),
		.vy                   (vy),
		.turn_term            (turn_term),
		.rate                 (wheel_two_rate)
	);

	omni_ik_wheel u_wheel_three (
		.clk                  (clk),
		.en                   (en),
		.angle                (wheel_three_angle_q),
		.inverse_wheel_radius (inverse_wheel_radius_q),
		.vx                   (vx),
		.vy                   (vy),
		.turn_term            (turn_term),
		.rate                 (wheel_three_rate)
	);

	omni_ik_wheel u_wheel_four (
		.clk                  (clk),
		.en                   (en),
		.angle                (omni_ik_pkg::DEG_ZERO),
		.inverse_wheel_radius (inverse_wheel_radius_q),
		.vx                   (vx),
		.vy                   (vy),
		.turn_term            (turn_term),
		.rate                 (wheel_four_rate)
	);

	assign m_axis_tdata = {wheel_four_rate, wheel_three_rate, wheel_two_rate, wheel_one_rate};

`ifndef ASSERT_OFF
	// An empty output stage never blocks the input.
	a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input not ready while output stage is empty");

	// An accepted item occupies the first stage on the next cycle.
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> valid_s1)
		else $error("accepted item missing from first stage");

	// A stalled stage keeps its item.
	a_stall_holds_s3: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && !en.s4) |=> valid_s3)
		else $error("stalled third stage lost its item");

	// A result that waits at the output, and the item behind it, are still there in the next cycle.
	a_stall_holds_out: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s6 && valid_s7 && !m_axis_tready) |=> (valid_s6 && valid_s7))
		else $error("stalled pipeline tail lost an item");
`endif

endmodule

@@ test/tb_omni_wheel_inverse_kinematics.sv @@
// Self-checking testbench for the four-wheel omni drive inverse kinematics block.
`timescale 1ns / 1ps

module tb_omni_wheel_inverse_kinematics;

	// One motion command, body_speed in the lowest bits as on the input bus.
	typedef struct packed {
		logic signed [15:0] turn_rate;
		logic signed [15:0] heading_deg;
		logic signed [15:0] body_speed;
	} motion_cmd_t;

	// One set of wheel rates, wheel one in the lowest bits as on the output bus.
	typedef struct packed {
		logic signed [23:0] wheel_four;
		logic signed [23:0] wheel_three;
		logic signed [23:0] wheel_two;
		logic signed [23:0] wheel_one;
	} wheel_rates_t;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

	localparam int FULL_TURN          = 360;
	localparam int QUARTER_TURN       = 90;
	localparam int HALF_TURN          = 180;
	localparam int THREE_QUARTER_TURN = 270;
	localparam omni_ik_pkg::cfg_index_t REG_LAST_INDEX = 3'd7;
	localparam int RANDOM_PHASES   = 8;
	localparam int ITEMS_PER_PHASE = 80;
	localparam int PIPE_QUIET      = 16;
	localparam int TIMEOUT_NS      = 2_000_000;

	// Quarter-wave sine in Q1.15, with 1.0 held as 32767.
	localparam int QUARTER_SINE [0:90] = '{
		0,     572,   1144,  1715,  2286,  2856,  3425,  3993,  4560,  5126,
		5690,  6253,  6813,  7371,  7927,  8481,  9032,  9580,  10126, 10668,
		11207, 11743, 12275, 12803, 13328, 13848, 14365, 14876, 15384, 15886,
		16384, 16877, 17364, 17847, 18324, 18795, 19261, 19720, 20174, 20622,
		21063, 21498, 21926, 22348, 22763, 23170, 23571, 23965, 24351, 24730,
		25102, 25466, 25822, 26170, 26510, 26842, 27166, 27482, 27789, 28088,
		28378, 28660, 28932, 29197, 29452, 29698, 29935, 30163, 30382, 30592,
		30792, 30983, 31164, 31336, 31499, 31651, 31795, 31928, 32052, 32166,
		32270, 32365, 32449, 32524, 32588, 32643, 32688, 32723, 32748, 32763,
		32767
	};

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata  = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [95:0] m_axis_tdata;
	logic        cfg_we        = 1'b0;
	omni_ik_pkg::cfg_index_t cfg_index = omni_ik_pkg::REG_WHEEL_ONE_ANGLE;
	logic [15:0] cfg_data      = '0;

	// Local copy of the register file, starting at the reset values.
	int     angle_one   = 90;
	int     angle_two   = 180;
	int     angle_three = 270;
	longint center_dist = 100;
	longint inv_radius  = 5120;

	motion_cmd_t  motion_cmd_q [$];
	wheel_rates_t wheel_rates_q [$];
	wheel_rates_t rates_due;
	wheel_rates_t rates_seen;
	int unsigned  send_idle_pct   = 0;
	int unsigned  recv_stall_pct  = 0;
	int unsigned  cmds_accepted   = 0;
	int unsigned  results_checked = 0;
	int unsigned  reg_settings    = 1;
	int unsigned  mismatch_count  = 0;

	omni_wheel_inverse_kinematics DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// Sine of an angle in 0..359 degrees, by quadrant symmetry.
	function automatic longint sine_of(int d);
		if (d <= QUARTER_TURN) begin
			return QUARTER_SINE[d];
		end else if (d <= HALF_TURN) begin
			return QUARTER_SINE[HALF_TURN - d];
		end else if (d <= THREE_QUARTER_TURN) begin
			return -QUARTER_SINE[d - HALF_TURN];
		end else begin
			return -QUARTER_SINE[FULL_TURN - d];
		end
	endfunction

	// Rate of one wheel: the Q.30 sum rounded to Q.8, scaled by the radius, rounded, clamped.
	function automatic logic signed [23:0] rate_for(int angle, longint turn, longint vx,
			longint vy);
		int     a;
		longint sum;
		longint q8;
		longint scaled;
		a      = angle % FULL_TURN;
		sum    = center_dist * turn * (longint'(1) <<< 30)
		         + vy * sine_of((a + QUARTER_TURN) % FULL_TURN) - vx * sine_of(a);
		q8     = (sum + (longint'(1) <<< 21)) >>> 22;
		scaled = (q8 * inv_radius + (longint'(1) <<< 15)) >>> 16;
		if (scaled > longint'(omni_ik_pkg::RATE_MAX)) begin
			scaled = longint'(omni_ik_pkg::RATE_MAX);
		end
		if (scaled < longint'(omni_ik_pkg::RATE_MIN)) begin
			scaled = longint'(omni_ik_pkg::RATE_MIN);
		end
		return scaled[23:0];
	endfunction

	// Expected wheel rates for one command under the current register copy.
	function automatic wheel_rates_t predict_wheel_rates(motion_cmd_t c);
		wheel_rates_t r;
		int           h;
		longint       vx;
		longint       vy;
		h = int'(c.heading_deg) % FULL_TURN;
		if (h < 0) begin
			h = h + FULL_TURN;
		end
		vx = longint'(c.body_speed) * sine_of((h + QUARTER_TURN) % FULL_TURN);
		vy = longint'(c.body_speed) * sine_of(h);
		r.wheel_one   = rate_for(angle_one, longint'(c.turn_rate), vx, vy);
		r.wheel_two   = rate_for(angle_two, longint'(c.turn_rate), vx, vy);
		r.wheel_three = rate_for(angle_three, longint'(c.turn_rate), vx, vy);
		r.wheel_four  = rate_for(0, longint'(c.turn_rate), vx, vy);
		return r;
	endfunction

	function automatic motion_cmd_t command_of(int speed, int heading, int turn);
		motion_cmd_t c;
		c.body_speed  = 16'(speed);
		c.heading_deg = 16'(heading);
		c.turn_rate   = 16'(turn);
		return c;
	endfunction

	// Random command: full-range fields mixed with small values that avoid saturation
	// and headings near the quadrant boundaries.
	function automatic motion_cmd_t random_command();
		motion_cmd_t c;
		case ($urandom_range(3))
			0: c.body_speed = 16'($urandom);
			1: c.body_speed = 16'($urandom_range(6000) - 3000);
			2: c.body_speed = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
			default: c.body_speed = 16'($urandom_range(100) - 50);
		endcase
		case ($urandom_range(2))
			0: c.heading_deg = 16'($urandom);
			1: c.heading_deg = 16'($urandom_range(1440) - 720);
			default: c.heading_deg = 16'((int'($urandom_range(16)) - 8) * QUARTER_TURN
			                             + int'($urandom_range(2)) - 1);
		endcase
		case ($urandom_range(2))
			0: c.turn_rate = 16'($urandom);
			1: c.turn_rate = 16'($urandom_range(600) - 300);
			default: c.turn_rate = 16'($urandom_range(4) - 2);
		endcase
		return c;
	endfunction

	function automatic void check_field(string name, logic signed [23:0] want,
			logic signed [23:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	// Register write; the local copy follows, and unused indexes change nothing.
	task automatic write_register(omni_ik_pkg::cfg_index_t idx, logic [15:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			omni_ik_pkg::REG_WHEEL_ONE_ANGLE:   angle_one   = int'(value[8:0]);
			omni_ik_pkg::REG_WHEEL_TWO_ANGLE:   angle_two   = int'(value[8:0]);
			omni_ik_pkg::REG_WHEEL_THREE_ANGLE: angle_three = int'(value[8:0]);
			omni_ik_pkg::REG_CENTER_DISTANCE:   center_dist = longint'(value);
			omni_ik_pkg::REG_INV_WHEEL_RADIUS:  inv_radius  = longint'(value);
			default: ;
		endcase
	endtask

	// Wait until every command is taken and answered, then let the pipeline settle.
	task automatic wait_drained();
		while (motion_cmd_q.size() != 0 || s_axis_tvalid || wheel_rates_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (PIPE_QUIET) @(negedge clk);
	endtask

	task automatic set_idling(idle_mode_e mode);
		case (mode)
			IDLE_NONE: begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			IDLE_SENDER: begin
				send_idle_pct  = 87;
				recv_stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				send_idle_pct  = 0;
				recv_stall_pct = 87;
			end
			default: begin
				send_idle_pct  = 17;
				recv_stall_pct = 17;
			end
		endcase
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Command driver: records the expectation of each accepted item and presents the next.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				wheel_rates_q.push_back(predict_wheel_rates(motion_cmd_t'(s_axis_tdata)));
				cmds_accepted++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (motion_cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					s_axis_tdata  <= motion_cmd_q.pop_front();
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compares each accepted item with the oldest expectation.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (wheel_rates_q.size() == 0) begin
					$error("wheel rates arrived with no command outstanding");
					mismatch_count++;
				end else begin
					rates_due  = wheel_rates_q.pop_front();
					rates_seen = wheel_rates_t'(m_axis_tdata);
					check_field("wheel_one_rate", rates_due.wheel_one,
						rates_seen.wheel_one);
					check_field("wheel_two_rate", rates_due.wheel_two,
						rates_seen.wheel_two);
					check_field("wheel_three_rate", rates_due.wheel_three,
						rates_seen.wheel_three);
					check_field("wheel_four_rate", rates_due.wheel_four,
						rates_seen.wheel_four);
					results_checked++;
				end
			end
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Phases: directed commands at reset settings, then random commands per setting.
	initial begin
		int p;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Zero, full-scale speeds, quadrant and wrap-around headings, extreme turn rates.
		motion_cmd_q.push_back(command_of(0, 0, 0));
		motion_cmd_q.push_back(command_of(32767, 0, 0));
		motion_cmd_q.push_back(command_of(-32768, 0, 0));
		motion_cmd_q.push_back(command_of(1000, 90, 0));
		motion_cmd_q.push_back(command_of(1000, 180, 0));
		motion_cmd_q.push_back(command_of(1000, 270, 0));
		motion_cmd_q.push_back(command_of(1000, -90, 0));
		motion_cmd_q.push_back(command_of(1000, -360, 0));
		motion_cmd_q.push_back(command_of(1000, 360, 0));
		motion_cmd_q.push_back(command_of(1000, 359, 0));
		motion_cmd_q.push_back(command_of(1000, -1, 0));
		motion_cmd_q.push_back(command_of(1000, 32767, 0));
		motion_cmd_q.push_back(command_of(1000, -32768, 0));
		motion_cmd_q.push_back(command_of(0, 0, 32767));
		motion_cmd_q.push_back(command_of(0, 0, -32768));
		motion_cmd_q.push_back(command_of(0, 0, 1));
		motion_cmd_q.push_back(command_of(0, 0, -1));
		motion_cmd_q.push_back(command_of(32767, 45, 32767));
		motion_cmd_q.push_back(command_of(-32768, 225, -32768));
		motion_cmd_q.push_back(command_of(-1, -1, -1));
		motion_cmd_q.push_back(command_of(32767, -32768, 32767));
		motion_cmd_q.push_back(command_of(-32768, 32767, -32768));
		motion_cmd_q.push_back(command_of(500, 30, -20));
		motion_cmd_q.push_back(command_of(1, 1, 1));
		wait_drained();

		for (p = 1; p <= RANDOM_PHASES; p++) begin
			case (p)
				1: begin
					// Smallest and largest in-range angles, the unused angle bits set, zero distance, unit radius.
					write_register(omni_ik_pkg::REG_WHEEL_ONE_ANGLE, 16'd0);
					write_register(omni_ik_pkg::REG_WHEEL_TWO_ANGLE, 16'd359);
					write_register(omni_ik_pkg::REG_WHEEL_THREE_ANGLE, 16'hFFFF);
					write_register(omni_ik_pkg::REG_CENTER_DISTANCE, 16'd0);
					write_register(omni_ik_pkg::REG_INV_WHEEL_RADIUS, 16'd1);
				end
				2: begin
					// Angles at and past a full turn, one below a quarter turn, and the largest distance and radius.
					write_register(omni_ik_pkg::REG_WHEEL_ONE_ANGLE, 16'd360);
					write_register(omni_ik_pkg::REG_WHEEL_TWO_ANGLE, 16'd511);
					write_register(omni_ik_pkg::REG_WHEEL_THREE_ANGLE, 16'd89);
					write_register(omni_ik_pkg::REG_CENTER_DISTANCE, 16'hFFFF);
					write_register(omni_ik_pkg::REG_INV_WHEEL_RADIUS, 16'hFFFF);
				end
				3: begin
					// A zero inverse radius forces every rate to zero.
					write_register(omni_ik_pkg::REG_WHEEL_ONE_ANGLE, 16'($urandom));
					write_register(omni_ik_pkg::REG_CENTER_DISTANCE, 16'hFFFF);
					write_register(omni_ik_pkg::REG_INV_WHEEL_RADIUS, 16'd0);
				end
				default: begin
					write_register(omni_ik_pkg::REG_WHEEL_ONE_ANGLE, 16'($urandom));
					write_register(omni_ik_pkg::REG_WHEEL_TWO_ANGLE, 16'($urandom));
					write_register(omni_ik_pkg::REG_WHEEL_THREE_ANGLE, 16'($urandom));
					write_register(omni_ik_pkg::REG_CENTER_DISTANCE,
						$urandom_range(1) ? 16'($urandom_range(300)) : 16'($urandom));
					write_register(omni_ik_pkg::REG_INV_WHEEL_RADIUS,
						$urandom_range(1) ? 16'($urandom_range(4096, 1)) : 16'($urandom));
				end
			endcase
			write_register(omni_ik_pkg::cfg_index_t'($urandom_range(REG_LAST_INDEX,
				omni_ik_pkg::REG_INV_WHEEL_RADIUS + 1)), 16'($urandom));
			reg_settings++;
			set_idling(idle_mode_e'(p % 4));
			repeat (ITEMS_PER_PHASE) motion_cmd_q.push_back(random_command());
			wait_drained();
		end

		$display("Checked %0d wheel rate sets from %0d commands across %0d register settings,",
			results_checked, cmds_accepted, reg_settings);
		$display("with sender gaps, receiver stalls, both and neither.");
		if (mismatch_count == 0) begin
			$display("omni_wheel_inverse_kinematics: match");
		end else begin
			$display("omni_wheel_inverse_kinematics: mismatch");
		end
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#(TIMEOUT_NS);
		$display("Timed out with %0d commands pending and %0d results outstanding.",
			motion_cmd_q.size(), wheel_rates_q.size());
		$display("omni_wheel_inverse_kinematics: mismatch");
		$finish;
	end

endmodule
